### hw/rtl/rsw_pkg.sv
// Shared types and constants for the receive sequence window.
// Used by the channel interfaces, rsw_window and receive_sequence_window_unit.
package rsw_pkg;

  localparam int unsigned SEQ_W       = 16;
  localparam int unsigned BITMAP_W    = 64;
  localparam int unsigned WINDOW_SIZE = 64;
  localparam int unsigned SHIFT_W     = $clog2(BITMAP_W);

  // Half of the sequence range: the serial-compare boundary
  localparam logic [SEQ_W-1:0] HalfRange = SEQ_W'(1) << (SEQ_W - 1);
  localparam logic [SEQ_W-1:0] WindowLen = SEQ_W'(WINDOW_SIZE);

  // One result as produced by the window logic
  typedef struct packed {
    logic                is_new;
    logic                extended_ack_needed;
    logic [SEQ_W-1:0]    extended_ack_sequence;
    logic [SEQ_W-1:0]    ack_sequence;
    logic [BITMAP_W-1:0] ack_bits;
  } rsw_result_t;

endpackage

### hw/rtl/rsw_req_if.sv
// Request channel: one received sequence number per request.
// Depends on rsw_pkg for the field width.
interface rsw_req_if;
  logic                    valid;
  logic                    ready;
  logic [rsw_pkg::SEQ_W-1:0] sequence_req;

  modport source (output valid, output sequence_req, input ready);
  modport sink   (input valid, input sequence_req, output ready);
endinterface

### hw/rtl/rsw_res_if.sv
// Result channel: new/duplicate verdict and the acknowledgement fields.
// Depends on rsw_pkg for the field widths.
interface rsw_res_if;
  logic                         valid;
  logic                         ready;
  logic                         is_new;
  logic                         extended_ack_needed;
  logic [rsw_pkg::SEQ_W-1:0]    extended_ack_sequence;
  logic [rsw_pkg::SEQ_W-1:0]    ack_sequence;
  logic [rsw_pkg::BITMAP_W-1:0] ack_bits;

  modport source (
    output valid, output is_new, output extended_ack_needed,
    output extended_ack_sequence, output ack_sequence, output ack_bits,
    input ready
  );
  modport sink (
    input valid, input is_new, input extended_ack_needed,
    input extended_ack_sequence, input ack_sequence, input ack_bits,
    output ready
  );
endinterface

### hw/rtl/receive_sequence_window_unit.sv
// Receive sequence window: duplicate detection over 16-bit wrapping sequences.
// Requests pass through the input register, then the result register.
// Throughput: one request per cycle while the result side is not stalling.
// Reset (rst_ni low, async): window empty, both registers empty, no result valid.
// Depends on rsw_pkg, rsw_req_if, rsw_res_if and rsw_window.
module receive_sequence_window_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsw_req_if.sink   req_i,
  rsw_res_if.source res_o
);
  import rsw_pkg::*;

  logic             in_valid_q;
  logic [SEQ_W-1:0] in_seq_q;
  logic             res_valid_q;
  rsw_result_t      res_q;
  rsw_result_t      res_d;
  logic             advance;
  logic             step;

  // Result register frees when empty or being taken
  assign advance     = !res_valid_q || res_o.ready;
  assign step        = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;

  // Input register: hold the request until it can be processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_seq_q <= req_i.sequence_req;
    end
  end

  rsw_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (step),
    .seq_i    (in_seq_q),
    .result_o (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid                 = res_valid_q;
  assign res_o.is_new                = res_q.is_new;
  assign res_o.extended_ack_needed   = res_q.extended_ack_needed;
  assign res_o.extended_ack_sequence = res_q.extended_ack_sequence;
  assign res_o.ack_sequence          = res_q.ack_sequence;
  assign res_o.ack_bits              = res_q.ack_bits;

`ifndef NO_ASSERTIONS
  // A packet flagged for extended ack is never reported as new
  a_ext_not_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_q.is_new && res_q.extended_ack_needed))
    else $error("result both new and extended ack");

  // Extended ack sequence reads zero unless flagged
  a_ext_seq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.extended_ack_needed) |-> (res_q.extended_ack_sequence == '0))
    else $error("extended ack sequence without flag");

  // A pending request waits in the input register while the result stalls
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_seq_q)))
    else $error("pending request dropped during stall");
`endif

endmodule

### hw/rtl/rsw_window.sv
// Window state (latest sequence, bitmap) and the per-request decision logic.
// Depends on rsw_pkg.
module rsw_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       update_i,
  input  logic [rsw_pkg::SEQ_W-1:0]  seq_i,
  output rsw_pkg::rsw_result_t       result_o
);
  import rsw_pkg::*;

  logic                seen_q, seen_d;
  logic [SEQ_W-1:0]    latest_q, latest_d;
  logic [BITMAP_W-1:0] bitmap_q, bitmap_d;

  logic [SEQ_W-1:0]    diff_up;
  logic [SEQ_W-1:0]    diff_dn;
  logic [SHIFT_W-1:0]  shamt;
  logic [SHIFT_W-1:0]  old_idx;
  logic [BITMAP_W-1:0] old_bit;
  logic                is_newer;
  logic                is_new;
  logic                ext_needed;

  // Serial distances both ways; a gap of exactly half the range counts as newer
  // only when the new sequence is numerically above the latest
  assign diff_up  = seq_i - latest_q;
  assign diff_dn  = latest_q - seq_i;
  assign is_newer = (diff_up != '0) &&
                    ((diff_up < HalfRange) || ((diff_up == HalfRange) && (seq_i > latest_q)));
  assign shamt    = diff_up[SHIFT_W-1:0];
  assign old_idx  = SHIFT_W'(diff_dn - SEQ_W'(1));
  assign old_bit  = BITMAP_W'(1) << old_idx;

  // Classify the request and form the next window
  always_comb begin
    seen_d     = seen_q;
    latest_d   = latest_q;
    bitmap_d   = bitmap_q;
    is_new     = 1'b0;
    ext_needed = 1'b0;
    if (!seen_q) begin
      seen_d   = 1'b1;
      latest_d = seq_i;
      bitmap_d = '0;
      is_new   = 1'b1;
    end else if (is_newer) begin
      latest_d = seq_i;
      is_new   = 1'b1;
      if (diff_up == HalfRange) begin
        bitmap_d = bitmap_q;
      end else if (diff_up >= WindowLen) begin
        bitmap_d = '0;
      end else begin
        bitmap_d = (bitmap_q << shamt) | (BITMAP_W'(1) << (shamt - SHIFT_W'(1)));
      end
    end else if (diff_up == '0) begin
      is_new = 1'b0;
    end else if (diff_dn <= WindowLen) begin
      if ((bitmap_q & old_bit) == '0) begin
        bitmap_d = bitmap_q | old_bit;
        is_new   = 1'b1;
      end
    end else begin
      ext_needed = 1'b1;
    end
  end

  always_comb begin
    result_o.is_new                = is_new;
    result_o.extended_ack_needed   = ext_needed;
    result_o.extended_ack_sequence = ext_needed ? seq_i : '0;
    result_o.ack_sequence          = latest_d;
    result_o.ack_bits              = bitmap_d;
  end

  // Commit the window when the request moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= 1'b0;
      latest_q <= '0;
      bitmap_q <= '0;
    end else if (update_i) begin
      seen_q   <= seen_d;
      latest_q <= latest_d;
      bitmap_q <= bitmap_d;
    end
  end

`ifndef NO_ASSERTIONS
  // Once a packet is seen the window never returns to empty
  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |=> seen_q)
    else $error("window lost its first-packet mark");

  // An ignored request leaves the window untouched
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !update_i |=> ($stable(latest_q) && $stable(bitmap_q)))
    else $error("window changed without a request");

  // Extended ack requests never change the window
  a_ext_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (update_i && ext_needed) |=> ($stable(latest_q) && $stable(bitmap_q)))
    else $error("extended ack request altered the window");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for receive_sequence_window_unit: duplicate detection over 16-bit sequences.
// Depends on rsw_pkg, rsw_req_if, rsw_res_if and the unit itself; predicts every result.
module tb;
  import rsw_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int MAX_REPORTED  = 10;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_ITEMS   = 150;

  logic clk_i = 1'b0;
  logic rst_ni;

  rsw_req_if req_if ();
  rsw_res_if res_if ();

  receive_sequence_window_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  // Window state as the unit should hold it
  logic                have_latest;
  logic [SEQ_W-1:0]    newest_seq;
  logic [BITMAP_W-1:0] recv_map;

  // Results predicted for accepted requests, oldest first
  rsw_result_t ack_results_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Advance the window by one received sequence and return the expected result
  function automatic rsw_result_t update_window(input logic [SEQ_W-1:0] seq);
    rsw_result_t        res;
    logic [SEQ_W-1:0]   ahead;
    logic [SEQ_W-1:0]   behind;
    logic [SHIFT_W-1:0] slot;
    res    = '0;
    ahead  = seq - newest_seq;
    behind = newest_seq - seq;
    slot   = SHIFT_W'(behind - 1'b1);
    if (!have_latest) begin
      have_latest = 1'b1;
      newest_seq  = seq;
      recv_map    = '0;
      res.is_new  = 1'b1;
    end else if (ahead != '0 &&
                 (ahead < HalfRange || (ahead == HalfRange && seq > newest_seq))) begin
      // Shift on a forward jump; a jump of half the range moves only the latest
      if (ahead < WindowLen) begin
        recv_map = (recv_map << ahead) | (BITMAP_W'(1) << (ahead - 1'b1));
      end else if (ahead != HalfRange) begin
        recv_map = '0;
      end
      newest_seq = seq;
      res.is_new = 1'b1;
    end else if (behind != '0 && behind <= WindowLen) begin
      // Test and set the bit of a late arrival inside the window
      if (!recv_map[slot]) begin
        recv_map[slot] = 1'b1;
        res.is_new = 1'b1;
      end
    end else if (behind != '0) begin
      res.extended_ack_needed   = 1'b1;
      res.extended_ack_sequence = seq;
    end
    res.ack_sequence = newest_seq;
    res.ack_bits     = recv_map;
    return res;
  endfunction

  // Offer one request after random idle cycles; predict its result on accept
  task automatic send_seq(input logic [SEQ_W-1:0] seq);
    rsw_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.sequence_req <= seq;
    do @(posedge clk_i); while (!req_if.ready);
    predicted     = update_window(seq);
    ack_results_q = {ack_results_q, predicted};
  endtask

  // Check each accepted result and drive a random stall on the result side
  always @(posedge clk_i) begin : result_check
    rsw_result_t got;
    rsw_result_t exp;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.is_new                = res_if.is_new;
      got.extended_ack_needed   = res_if.extended_ack_needed;
      got.extended_ack_sequence = res_if.extended_ack_sequence;
      got.ack_sequence          = res_if.ack_sequence;
      got.ack_bits              = res_if.ack_bits;
      if (ack_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED) begin
          $display("unexpected result: new=%b ext=%b ext_seq=%h ack=%h bits=%h",
                   got.is_new, got.extended_ack_needed, got.extended_ack_sequence,
                   got.ack_sequence, got.ack_bits);
        end
      end else begin
        exp = ack_results_q.pop_front();
        if (got.is_new !== exp.is_new ||
            got.extended_ack_needed !== exp.extended_ack_needed ||
            got.extended_ack_sequence !== exp.extended_ack_sequence ||
            got.ack_sequence !== exp.ack_sequence ||
            got.ack_bits !== exp.ack_bits) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED) begin
            $display("mismatch exp: new=%b ext=%b ext_seq=%h ack=%h bits=%h",
                     exp.is_new, exp.extended_ack_needed, exp.extended_ack_sequence,
                     exp.ack_sequence, exp.ack_bits);
            $display("         got: new=%b ext=%b ext_seq=%h ack=%h bits=%h",
                     got.is_new, got.extended_ack_needed, got.extended_ack_sequence,
                     got.ack_sequence, got.ack_bits);
          end
        end
      end
    end
    res_if.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Walk the window edges: first packet, wrap, gaps around the window and half range
  task automatic test_window_edges();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_seq(16'hFFFF);
    send_seq(16'h0000);
    send_seq(16'h003F);
    send_seq(16'h003F);
    send_seq(16'h003E);
    send_seq(16'h003E);
    send_seq(16'h0000);
    send_seq(16'hFFFF);
    send_seq(16'hFFFE);
    send_seq(16'h007F);
    send_seq(16'h003F);
    send_seq(16'h807F);
    send_seq(16'h007F);
    send_seq(16'h007E);
    send_seq(16'h007F);
    send_seq(16'h00BE);
    send_seq(16'h00BF);
    send_seq(16'h007F);
    send_seq(16'h0080);
    send_seq(16'hFFFF);
    send_seq(16'h0000);
    send_seq(16'h00C0);
  endtask

  // Small forward steps mixed with late arrivals, repeats and jumps of every size
  task automatic test_mixed_arrivals(input int idle_pct, input int stall_pct);
    logic [SEQ_W-1:0] seq;
    int               pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 42) begin
        seq = newest_seq + SEQ_W'($urandom_range(5, 1));
      end else if (pick < 58) begin
        seq = newest_seq - SEQ_W'($urandom_range(WINDOW_SIZE, 1));
      end else if (pick < 65) begin
        seq = newest_seq;
      end else if (pick < 75) begin
        seq = newest_seq + SEQ_W'($urandom_range(WINDOW_SIZE + 6, 6));
      end else if (pick < 82) begin
        seq = newest_seq - SEQ_W'($urandom_range(HalfRange, WINDOW_SIZE + 1));
      end else if (pick < 88) begin
        seq = newest_seq + SEQ_W'($urandom_range(HalfRange, WINDOW_SIZE + 7));
      end else if (pick < 92) begin
        seq = newest_seq ^ HalfRange;
      end else begin
        seq = SEQ_W'($urandom);
      end
      send_seq(seq);
    end
  endtask

  initial begin
    have_latest         = 1'b0;
    newest_seq          = '0;
    recv_map            = '0;
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.sequence_req = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_window_edges();
    test_mixed_arrivals(0, 0);
    test_mixed_arrivals(56, 0);
    test_mixed_arrivals(0, 56);
    test_mixed_arrivals(30, 30);

    // Drop the request and let the last results drain
    req_if.valid <= 1'b0;
    while (ack_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rsw_pkg.sv
hw/rtl/rsw_req_if.sv
hw/rtl/rsw_res_if.sv
hw/rtl/rsw_window.sv
hw/rtl/receive_sequence_window_unit.sv
tb/sv/tb.sv
